// File: rtl/stcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scalar cast package
// Type codes, item structs and the two conversion functions.
// ----------------------------------------------------------------------------
package stcc_pkg;

  typedef enum logic [1:0] {
    TY_INT   = 2'd0,
    TY_FLOAT = 2'd1,
    TY_BOOL  = 2'd2,
    TY_TYPE  = 2'd3
  } ty_e;

  typedef struct packed {
    logic [31:0] raw_word;
    logic [1:0]  target_type;
    logic [1:0]  source_type;
  } in_item_t;

  typedef struct packed {
    logic        saturated;
    logic        is_subtype;
    logic [31:0] result_word;
  } out_item_t;

  localparam logic [31:0] FLOAT_ONE = 32'h3F80_0000;
  localparam logic [31:0] INT_MIN   = 32'h8000_0000;
  localparam logic [31:0] INT_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] FLOAT_M31 = 32'hCF00_0000;

  function automatic logic [31:0] int_to_float(input logic [31:0] w);
    logic [31:0] mag;
    logic [4:0]  p;
    logic [31:0] norm;
    logic [23:0] mant;
    logic        guard;
    logic        sticky;
    logic [24:0] mant_r;
    logic [31:0] res;
    mag  = w[31] ? (32'd0 - w) : w;
    p    = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) p = 5'(i);
    end
    norm   = mag << (5'd31 - p);
    mant   = norm[31:8];
    guard  = norm[7];
    sticky = |norm[6:0];
    mant_r = {1'b0, mant} + 25'(guard && (sticky || mant[0]));
    res    = {w[31], 31'd0} | (({24'd0, 8'd126 + {3'd0, p}} << 23) + {7'd0, mant_r});
    if (w == 32'd0) res = 32'd0;
    return res;
  endfunction

  function automatic logic [32:0] float_to_int(input logic [31:0] w);
    logic [7:0]  e;
    logic [22:0] frac;
    logic [7:0]  u;
    logic [54:0] sh;
    logic [31:0] mag;
    logic [32:0] res;
    e    = w[30:23];
    frac = w[22:0];
    u    = e - 8'd127;
    sh   = {31'd0, 1'b1, frac} << u[4:0];
    mag  = sh[54:23];
    res  = {1'b0, w[31] ? (32'd0 - mag) : mag};
    if (e == 8'hFF && frac != 23'd0) begin
      res = {1'b1, 32'd0};
    end else if (e < 8'd127) begin
      res = 33'd0;
    end else if (u >= 8'd31) begin
      if (w == FLOAT_M31) res = {1'b0, INT_MIN};
      else res = {1'b1, w[31] ? INT_MIN : INT_MAX};
    end
    return res;
  endfunction

endpackage

// File: rtl/scalar_type_cast_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scalar type cast converter
// Recasts a 32-bit word between integer, float, boolean and type codes.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (tdata, low bit first)
// s_axis   in   source_type[1:0], target_type[3:2], raw_word[35:4]
// m_axis   out  result_word[31:0], is_subtype[32], saturated[33]
//
// One item per cycle unless the output stalls; each item passes the input
// register, then the result register. Reset empties both registers.
// A stalled result holds; the input stage advances whenever it is empty or
// the result register is free or being taken.
// ----------------------------------------------------------------------------
module scalar_type_cast_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // source_type, target_type, raw_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // result_word, is_subtype, saturated
);

  stcc_pkg::in_item_t  in_q;
  stcc_pkg::out_item_t res_d, res_q;
  logic                in_vld_q, out_vld_q;
  logic                out_adv, in_adv;

  assign out_adv       = !out_vld_q || m_axis_tready;
  assign in_adv        = !in_vld_q || out_adv;
  assign s_axis_tready = in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_adv) in_vld_q <= s_axis_tvalid;
      if (out_adv) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && s_axis_tvalid) in_q <= stcc_pkg::in_item_t'(s_axis_tdata[35:0]);
    if (out_adv && in_vld_q) res_q <= res_d;
  end

  stcc_core u_core (
    .item_i(in_q),
    .res_o (res_d)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, res_q};

endmodule

// File: rtl/stcc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scalar cast core
// Combinational cast of one registered item to its result.
// ----------------------------------------------------------------------------
module stcc_core (
  input  stcc_pkg::in_item_t  item_i,
  output stcc_pkg::out_item_t res_o
);

  logic [32:0] f2i;
  logic [31:0] w;
  logic        b;

  assign w   = item_i.raw_word;
  assign b   = w[7:0] != 8'd0;
  assign f2i = stcc_pkg::float_to_int(w);

  always_comb begin
    res_o.result_word = 32'd0;
    res_o.saturated   = 1'b0;
    res_o.is_subtype  = (item_i.source_type == item_i.target_type) ||
                        (item_i.source_type == stcc_pkg::TY_INT &&
                         item_i.target_type == stcc_pkg::TY_FLOAT);
    if (item_i.source_type == item_i.target_type) begin
      res_o.result_word = w;
    end else begin
      case (stcc_pkg::ty_e'(item_i.source_type))
        stcc_pkg::TY_BOOL: begin
          if (item_i.target_type == stcc_pkg::TY_INT) res_o.result_word = {31'd0, b};
          else if (item_i.target_type == stcc_pkg::TY_FLOAT)
            res_o.result_word = b ? stcc_pkg::FLOAT_ONE : 32'd0;
        end
        stcc_pkg::TY_INT: begin
          if (item_i.target_type == stcc_pkg::TY_BOOL) res_o.result_word = {31'd0, w != 32'd0};
          else if (item_i.target_type == stcc_pkg::TY_FLOAT)
            res_o.result_word = stcc_pkg::int_to_float(w);
        end
        stcc_pkg::TY_FLOAT: begin
          if (item_i.target_type == stcc_pkg::TY_INT) begin
            res_o.result_word = f2i[31:0];
            res_o.saturated   = f2i[32];
          end else if (item_i.target_type == stcc_pkg::TY_BOOL) begin
            res_o.result_word = {31'd0, w[30:0] != 31'd0};
          end
        end
        default: res_o.result_word = 32'd0;
      endcase
    end
  end

endmodule
